// ===== sv/mtrl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrl_pkg
// Types, request codes and table geometry for the multibit trie route lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package mtrl_pkg;

  // Table geometry: the top level is indexed by key bits 31..16; lower levels
  // are built of 256-entry chunks selected by a child number.
  localparam int TOP_LEVEL_ENTRIES   = 65536;
  localparam int LOWER_LEVEL_ENTRIES = 65536;
  localparam int CHUNK_SIZE          = 256;
  localparam int CHUNK_COUNT         = LOWER_LEVEL_ENTRIES / CHUNK_SIZE;
  localparam int TOP_ADDR_W          = $clog2(TOP_LEVEL_ENTRIES);
  localparam int LOWER_ADDR_W        = $clog2(LOWER_LEVEL_ENTRIES);
  localparam int BYTE_W              = $clog2(CHUNK_SIZE);
  localparam int CHUNK_SEL_W         = LOWER_ADDR_W - BYTE_W;

  localparam int HOP_W   = 8;
  localparam int CHILD_W = 16;

  // Request codes
  localparam logic [2:0] REQ_LOOKUP      = 3'd0;
  localparam logic [2:0] REQ_WR_HOP16    = 3'd1;
  localparam logic [2:0] REQ_WR_CHILD16  = 3'd2;
  localparam logic [2:0] REQ_WR_HOP24    = 3'd3;
  localparam logic [2:0] REQ_WR_CHILD24  = 3'd4;
  localparam logic [2:0] REQ_WR_HOP32    = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] key_prefix;
    logic [15:0] table_address;
    logic [15:0] table_data;
  } mtrl_req_t;

  typedef struct packed {
    logic [7:0] next_hop;
    logic       route_found;
  } mtrl_result_t;

  // Clearing sweep that zeroes every table after reset.
  typedef struct packed {
    logic                  active;
    logic [TOP_ADDR_W-1:0] addr;
  } mtrl_clear_t;

  // One pipeline slot: the request, the hop found so far, whether the walk
  // goes on, and the entries read for this slot at the previous level.
  typedef struct packed {
    logic               valid;
    mtrl_req_t          req;
    logic [HOP_W-1:0]   hop;
    logic               walk;
    logic [HOP_W-1:0]   hop_rd;
    logic [CHILD_W-1:0] child_rd;
  } mtrl_stage_t;

endpackage

`default_nettype wire

// ===== sv/mtrl_clear.sv =====
// ----------------------------------------------------------------------------
// mtrl_clear
// Address sweep that zeroes all trie tables, one entry per cycle, after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrl_clear
  import mtrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  output mtrl_clear_t clr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr.active <= 1'b1;
      clr.addr   <= '0;
    end else if (clr.active) begin
      clr.addr <= clr.addr + 1'b1;
      if (clr.addr == TOP_ADDR_W'(TOP_LEVEL_ENTRIES - 1)) begin
        clr.active <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtrl_level16.sv =====
// ----------------------------------------------------------------------------
// mtrl_level16
// First trie level: hop and child tables indexed by key bits 31..16.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrl_level16
  import mtrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mtrl_clear_t clr,
  input  logic        in_valid,
  input  mtrl_req_t   req,
  output mtrl_stage_t s_out
);

  logic [HOP_W-1:0]   hop_mem   [TOP_LEVEL_ENTRIES];
  logic [CHILD_W-1:0] child_mem [TOP_LEVEL_ENTRIES];
  logic [TOP_ADDR_W-1:0] rd_idx;
  logic [TOP_ADDR_W-1:0] wr_idx;
  logic                  wr_ok;

  assign rd_idx = req.key_prefix[31 -: TOP_ADDR_W];
  assign wr_idx = req.table_address[TOP_ADDR_W-1:0];
  assign wr_ok  = in_valid && (32'(req.table_address) < TOP_LEVEL_ENTRIES);

  always_ff @(posedge clk) begin
    if (clr.active) begin
      hop_mem[clr.addr]   <= '0;
      child_mem[clr.addr] <= '0;
    end else if (wr_ok && req.req_type == REQ_WR_HOP16) begin
      hop_mem[wr_idx] <= req.table_data[HOP_W-1:0];
    end else if (wr_ok && req.req_type == REQ_WR_CHILD16) begin
      child_mem[wr_idx] <= req.table_data;
    end
  end

  always_ff @(posedge clk) begin
    s_out.hop_rd   <= hop_mem[rd_idx];
    s_out.child_rd <= child_mem[rd_idx];
    s_out.req      <= req;
    s_out.hop      <= '0;
    s_out.walk     <= 1'b1;
    if (rst) begin
      s_out.valid <= 1'b0;
    end else begin
      s_out.valid <= in_valid;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtrl_level24.sv =====
// ----------------------------------------------------------------------------
// mtrl_level24
// Second trie level: merge the level-16 entries, then read the level-24 chunk.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrl_level24
  import mtrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mtrl_clear_t clr,
  input  mtrl_stage_t s_in,
  output mtrl_stage_t s_out
);

  logic [HOP_W-1:0]   hop_mem   [LOWER_LEVEL_ENTRIES];
  logic [CHILD_W-1:0] child_mem [LOWER_LEVEL_ENTRIES];
  logic [HOP_W-1:0]        hop_cur;
  logic [CHILD_W-1:0]      chunk;
  logic                    walk_on;
  logic [LOWER_ADDR_W-1:0] rd_idx;
  logic [LOWER_ADDR_W-1:0] wr_idx;
  logic                    wr_ok;

  always_comb begin
    hop_cur = (s_in.walk && s_in.hop_rd != '0) ? s_in.hop_rd : s_in.hop;
    chunk   = s_in.child_rd - 1'b1;
    // A child of zero, or any child above CHUNK_COUNT, ends the walk.
    walk_on = s_in.walk && (s_in.child_rd != '0) && (32'(chunk) < CHUNK_COUNT);
    rd_idx  = {chunk[CHUNK_SEL_W-1:0], s_in.req.key_prefix[15:8]};
    wr_idx  = s_in.req.table_address[LOWER_ADDR_W-1:0];
    wr_ok   = s_in.valid && (32'(s_in.req.table_address) < LOWER_LEVEL_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (clr.active) begin
      hop_mem[clr.addr[LOWER_ADDR_W-1:0]]   <= '0;
      child_mem[clr.addr[LOWER_ADDR_W-1:0]] <= '0;
    end else if (wr_ok && s_in.req.req_type == REQ_WR_HOP24) begin
      hop_mem[wr_idx] <= s_in.req.table_data[HOP_W-1:0];
    end else if (wr_ok && s_in.req.req_type == REQ_WR_CHILD24) begin
      child_mem[wr_idx] <= s_in.req.table_data;
    end
  end

  always_ff @(posedge clk) begin
    s_out.hop_rd   <= hop_mem[rd_idx];
    s_out.child_rd <= child_mem[rd_idx];
    s_out.req      <= s_in.req;
    s_out.hop      <= hop_cur;
    s_out.walk     <= walk_on;
    if (rst) begin
      s_out.valid <= 1'b0;
    end else begin
      s_out.valid <= s_in.valid;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtrl_level32.sv =====
// ----------------------------------------------------------------------------
// mtrl_level32
// Third trie level: merge the level-24 entries, then read the level-32 hop.
// ----------------------------------------------------------------------------
`default_nettype none

module mtrl_level32
  import mtrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mtrl_clear_t clr,
  input  mtrl_stage_t s_in,
  output mtrl_stage_t s_out
);

  logic [HOP_W-1:0] hop_mem [LOWER_LEVEL_ENTRIES];
  logic [HOP_W-1:0]        hop_cur;
  logic [CHILD_W-1:0]      chunk;
  logic                    walk_on;
  logic [LOWER_ADDR_W-1:0] rd_idx;
  logic [LOWER_ADDR_W-1:0] wr_idx;
  logic                    wr_ok;

  always_comb begin
    hop_cur = (s_in.walk && s_in.hop_rd != '0) ? s_in.hop_rd : s_in.hop;
    chunk   = s_in.child_rd - 1'b1;
    walk_on = s_in.walk && (s_in.child_rd != '0) && (32'(chunk) < CHUNK_COUNT);
    rd_idx  = {chunk[CHUNK_SEL_W-1:0], s_in.req.key_prefix[7:0]};
    wr_idx  = s_in.req.table_address[LOWER_ADDR_W-1:0];
    wr_ok   = s_in.valid && (32'(s_in.req.table_address) < LOWER_LEVEL_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (clr.active) begin
      hop_mem[clr.addr[LOWER_ADDR_W-1:0]] <= '0;
    end else if (wr_ok && s_in.req.req_type == REQ_WR_HOP32) begin
      hop_mem[wr_idx] <= s_in.req.table_data[HOP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s_out.hop_rd   <= hop_mem[rd_idx];
    s_out.child_rd <= '0;
    s_out.req      <= s_in.req;
    s_out.hop      <= hop_cur;
    s_out.walk     <= walk_on;
    if (rst) begin
      s_out.valid <= 1'b0;
    end else begin
      s_out.valid <= s_in.valid;
    end
  end

endmodule

`default_nettype wire

// ===== sv/multibit_trie_route_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// multibit_trie_route_lookup_unit
// Three-level (16/8/8) multibit trie longest-prefix route lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req and raise start; the transfer happens at a rising
//   edge where start is high and busy is low. A lookup (req_type lookup) walks
//   the trie on key_prefix; the write codes load one table entry and give no
//   result. Unused codes pass through and do nothing.
//   Result channel: done pulses for one cycle with result valid in that cycle.
//   The receiver cannot hold results off and must take every one.
//   Pipeline: a lookup passes four register stages (level-16 read, level-24
//   read, level-32 read, output register) before its result shows.
//   Throughput: one request every cycle while busy is low; each trie
//   level owns its own table memories, one read port and one write port each,
//   and a write travels down the same pipeline so it lands in order with
//   lookups.
//   Reset: rst clears the pipeline and starts a clearing pass that zeroes all
//   tables, one entry per cycle; busy is high throughout.
//   After that busy stays low and the block never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module multibit_trie_route_lookup_unit
  import mtrl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  mtrl_req_t    req,
  output logic         done,
  output mtrl_result_t result
);

  mtrl_clear_t clr;
  mtrl_stage_t s1;
  mtrl_stage_t s2;
  mtrl_stage_t s3;
  logic        accept;
  logic [HOP_W-1:0] hop_final;

  // Hold off requests while the tables are being zeroed.
  assign busy   = clr.active;
  assign accept = start && !busy;

  mtrl_clear u_clear (
    .clk (clk),
    .rst (rst),
    .clr (clr)
  );

  // Stage 1: top-level hop and child read, level-16 writes.
  mtrl_level16 u_level16 (
    .clk      (clk),
    .rst      (rst),
    .clr      (clr),
    .in_valid (accept),
    .req      (req),
    .s_out    (s1)
  );

  // Stage 2: resolve level 16, read the selected level-24 chunk entry.
  mtrl_level24 u_level24 (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr),
    .s_in  (s1),
    .s_out (s2)
  );

  // Stage 3: resolve level 24, read the selected level-32 hop.
  mtrl_level32 u_level32 (
    .clk   (clk),
    .rst   (rst),
    .clr   (clr),
    .s_in  (s2),
    .s_out (s3)
  );

  // A nonzero level-32 hop on a live walk overrides the shorter match.
  assign hop_final = (s3.walk && s3.hop_rd != '0) ? s3.hop_rd : s3.hop;

  // Output register: only lookups produce a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3.valid && (s3.req.req_type == REQ_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    result.next_hop    <= hop_final;
    result.route_found <= (hop_final != '0);
  end

endmodule

`default_nettype wire
